>>> sv/hscan_pkg.sv
// ----------------------------------------------------------------------------
// hscan_pkg
// Shared types and constants of the header end and content length scanner.
// ----------------------------------------------------------------------------
package hscan_pkg;

  localparam int unsigned HeaderDepth = 65536;
  localparam int unsigned BodyDepth   = 4194304;
  localparam int unsigned HlimW       = 17;
  localparam int unsigned BlimW       = 23;
  localparam int unsigned CfgW        = 23;
  localparam int unsigned KeyLen      = 15;
  localparam int unsigned NKeys       = 3;

  localparam logic [0:0] CfgHeaderLimit = 1'b0;
  localparam logic [0:0] CfgBodyLimit   = 1'b1;

  typedef enum logic [0:0] {
    FUNC_DATA    = 1'b0,
    FUNC_RESTART = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_HDR_END  = 3'd1,
    KIND_BODY_OK  = 3'd2,
    KIND_BODY_REJ = 3'd3,
    KIND_OVERFLOW = 3'd4,
    KIND_RESTART  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    EM_IDLE    = 3'd0,
    EM_CR      = 3'd1,
    EM_LF      = 3'd2,
    EM_CRLF    = 3'd3,
    EM_CRLFCR  = 3'd4
  } em_e;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [3:0]  progress;
    logic        found;
    logic        any;
    logic        prev_cr;
    logic        cr_first;
    phase_e      phase;
    logic        neg;
    logic [31:0] mag;
    logic        lf_done;
    logic [31:0] lf_val;
    logic        crlf_done;
    logic [31:0] crlf_val;
  } key_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    kind_e       byte_kind;
    logic        header_done;
    logic [31:0] content_length;
    logic [16:0] header_bytes;
    logic [22:0] body_bytes;
  } out_t;

  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] p);
    logic [7:0] c;
    case (p)
      4'd0:  c = (k == 2'd2) ? 8'h63 : 8'h43;
      4'd1:  c = 8'h6f;
      4'd2:  c = 8'h6e;
      4'd3:  c = 8'h74;
      4'd4:  c = 8'h65;
      4'd5:  c = 8'h6e;
      4'd6:  c = 8'h74;
      4'd7:  c = 8'h2d;
      4'd8:  c = (k == 2'd0) ? 8'h4c : 8'h6c;
      4'd9:  c = 8'h65;
      4'd10: c = 8'h6e;
      4'd11: c = 8'h67;
      4'd12: c = 8'h74;
      4'd13: c = 8'h68;
      4'd14: c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] cur_value(input key_t k);
    logic [31:0] v;
    if (k.phase == PH_SKIP || k.phase == PH_SIGN) begin
      v = 32'd0;
    end else if (k.neg) begin
      v = 32'd0 - k.mag;
    end else begin
      v = k.mag[31] ? 32'h7fff_ffff : k.mag;
    end
    return v;
  endfunction

  function automatic key_t key_step(input key_t k, input logic [1:0] idx,
                                    input logic [7:0] b);
    key_t       n;
    logic       first;
    logic       digit;
    logic       blank;
    logic [35:0] m;
    n = k;
    first = !k.any;
    digit = (b >= 8'h30) && (b <= 8'h39);
    blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
    m = 36'd0;
    if (!k.found) begin
      if (k.progress < 4'(KeyLen) && b == key_char(idx, k.progress)) begin
        n.progress = k.progress + 4'd1;
      end else begin
        n.progress = (b == key_char(idx, 4'd0)) ? 4'd1 : 4'd0;
      end
      if (n.progress >= 4'(KeyLen)) begin
        n.found = 1'b1;
      end
    end else begin
      n.any = 1'b1;
      if (b == 8'h0a) begin
        if (!k.lf_done) begin
          n.lf_done = 1'b1;
          n.lf_val  = first ? 32'hffff_ffff : cur_value(k);
        end
        if (k.prev_cr && !k.crlf_done) begin
          n.crlf_done = 1'b1;
          n.crlf_val  = k.cr_first ? 32'hffff_ffff : cur_value(k);
        end
      end
      case (k.phase)
        PH_SKIP: begin
          if (!blank) begin
            if (b == 8'h2b || b == 8'h2d) begin
              n.neg   = (b == 8'h2d);
              n.phase = PH_SIGN;
            end else begin
              n.phase = digit ? PH_DIGITS : PH_DONE;
            end
          end
        end
        PH_SIGN:   n.phase = digit ? PH_DIGITS : PH_DONE;
        PH_DIGITS: if (!digit) n.phase = PH_DONE;
        default:   n.phase = k.phase;
      endcase
      if (n.phase == PH_DIGITS && digit) begin
        // times ten as two shifts, saturating at 2^31
        m = {4'd0, k.mag} + {1'b0, k.mag, 3'd0} + {3'd0, k.mag, 1'b0} - {4'd0, k.mag}
            + {28'd0, b - 8'h30};
        n.mag = (m > 36'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
      end
      n.prev_cr  = (b == 8'h0d);
      n.cr_first = (b == 8'h0d) && first;
    end
    return n;
  endfunction

endpackage

>>> sv/hscan_if.sv
// ----------------------------------------------------------------------------
// hscan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hscan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/http_header_end_and_length_scanner_unit.sv
// ----------------------------------------------------------------------------
// http_header_end_and_length_scanner_unit
// Finds the header end of an HTTP message and parses its content length.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_if    in   func, data_byte
// out_if   out  byte_kind, header_done, content_length, header_bytes, body_bytes
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// one beat per cycle unless the output stalls; each result leaves the cycle after
// its byte, from the single register stage holding matcher state and result.
// the input is ready whenever the result register is empty or being taken.
// reset gives the register defaults and a cleared parse state.
// ----------------------------------------------------------------------------
module http_header_end_and_length_scanner_unit #(
  parameter int unsigned HEADER_DEPTH = hscan_pkg::HeaderDepth,
  parameter int unsigned BODY_DEPTH   = hscan_pkg::BodyDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  hscan_if.sink                       in_if,
  hscan_if.source                     out_if,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [hscan_pkg::CfgW-1:0]  cfg_data_i
);

  localparam int unsigned HW = hscan_pkg::HlimW;
  localparam int unsigned BW = hscan_pkg::BlimW;
  localparam logic [HW:0] HDepth = (HEADER_DEPTH > 131071) ? (HW+1)'(131071)
                                                            : (HW+1)'(HEADER_DEPTH);
  localparam logic [BW:0] BDepth = (BODY_DEPTH > 8388607) ? (BW+1)'(8388607)
                                                          : (BW+1)'(BODY_DEPTH);

  logic [HW-1:0] hlim_q;
  logic [BW-1:0] blim_q;
  logic          in_body_q, in_body_d;
  hscan_pkg::em_e em_q, em_d;
  logic [HW-1:0] hcnt_q, hcnt_d;
  logic [BW-1:0] bcnt_q, bcnt_d;
  hscan_pkg::key_t [2:0] keys_q, keys_d;
  logic [31:0]   len_q, len_d;
  logic          ovalid_q;
  hscan_pkg::out_t res_q, res_d;
  logic          take;

  logic [HW:0] hl;
  logic [BW:0] bl;
  logic        ended;
  hscan_pkg::kind_e kind;

  assign in_if.ready  = !ovalid_q || out_if.ready;
  assign take         = in_if.valid && in_if.ready;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  always_comb begin
    hl = ({1'b0, hlim_q} < HDepth) ? {1'b0, hlim_q} : HDepth;
    bl = ({1'b0, blim_q} < BDepth) ? {1'b0, blim_q} : BDepth;
    in_body_d = in_body_q;
    em_d      = em_q;
    hcnt_d    = hcnt_q;
    bcnt_d    = bcnt_q;
    keys_d    = keys_q;
    len_d     = len_q;
    ended     = 1'b0;
    kind      = hscan_pkg::KIND_HEADER;
    if (in_if.data.func == hscan_pkg::FUNC_RESTART) begin
      in_body_d = 1'b0;
      em_d      = hscan_pkg::EM_IDLE;
      hcnt_d    = '0;
      bcnt_d    = '0;
      keys_d    = '0;
      len_d     = 32'hffff_ffff;
      kind      = hscan_pkg::KIND_RESTART;
    end else if (!in_body_q) begin
      if ({1'b0, hcnt_q} + (HW+1)'(1) >= hl) begin
        kind = hscan_pkg::KIND_OVERFLOW;
      end else begin
        hcnt_d = hcnt_q + HW'(1);
        for (int i = 0; i < 3; i++) begin
          keys_d[i] = hscan_pkg::key_step(keys_q[i], 2'(i), in_if.data.data_byte);
        end
        if (in_if.data.data_byte == 8'h0a) begin
          if (em_q == hscan_pkg::EM_LF || em_q == hscan_pkg::EM_CRLF ||
              em_q == hscan_pkg::EM_CRLFCR) begin
            em_d  = hscan_pkg::EM_IDLE;
            ended = 1'b1;
          end else begin
            em_d = (em_q == hscan_pkg::EM_CR) ? hscan_pkg::EM_CRLF : hscan_pkg::EM_LF;
          end
        end else if (in_if.data.data_byte == 8'h0d) begin
          em_d = (em_q == hscan_pkg::EM_CRLF) ? hscan_pkg::EM_CRLFCR : hscan_pkg::EM_CR;
        end else begin
          em_d = hscan_pkg::EM_IDLE;
        end
        if (ended) begin
          in_body_d = 1'b1;
          kind      = hscan_pkg::KIND_HDR_END;
          len_d     = 32'hffff_ffff;
          // key priority: the lowest-index key found wins
          for (int i = 2; i >= 0; i--) begin
            if (keys_d[i].found) begin
              if (keys_d[i].crlf_done)    len_d = keys_d[i].crlf_val;
              else if (keys_d[i].lf_done) len_d = keys_d[i].lf_val;
              else                        len_d = 32'hffff_ffff;
            end
          end
        end
      end
    end else begin
      if (!len_q[31] && len_q != 32'd0 && ({1'b0, bcnt_q} + (BW+1)'(1) <= bl)) begin
        bcnt_d = bcnt_q + BW'(1);
        kind   = hscan_pkg::KIND_BODY_OK;
      end else begin
        kind = hscan_pkg::KIND_BODY_REJ;
      end
    end
    res_d.byte_kind      = kind;
    res_d.header_done    = in_body_d;
    res_d.content_length = len_d;
    res_d.header_bytes   = hcnt_d;
    res_d.body_bytes     = bcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hlim_q    <= HW'(65536);
      blim_q    <= BW'(4194304);
      in_body_q <= 1'b0;
      em_q      <= hscan_pkg::EM_IDLE;
      hcnt_q    <= '0;
      bcnt_q    <= '0;
      keys_q    <= '0;
      len_q     <= 32'hffff_ffff;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == hscan_pkg::CfgHeaderLimit) hlim_q <= cfg_data_i[HW-1:0];
        else                                        blim_q <= cfg_data_i[BW-1:0];
      end
      if (take) begin
        in_body_q <= in_body_d;
        em_q      <= em_d;
        hcnt_q    <= hcnt_d;
        bcnt_q    <= bcnt_d;
        keys_q    <= keys_d;
        len_q     <= len_d;
        ovalid_q  <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

>>> sv/hscan_checker.sv
// ----------------------------------------------------------------------------
// hscan_checker
// Port level checks of the scanner.
// ----------------------------------------------------------------------------
module hscan_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input hscan_pkg::out_t  out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat gave no result");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_data.byte_kind == hscan_pkg::KIND_BODY_OK ||
                  out_data.byte_kind == hscan_pkg::KIND_HDR_END) |-> out_data.header_done)
    else $error("body beat without header end");

endmodule

bind http_header_end_and_length_scanner_unit hscan_checker u_hscan_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the HTTP header end and content length scanner. Byte streams made of
// header lines, length keys with varied values, blank-line terminators and
// body bytes are sent. Each result is compared with an in-bench prediction of
// the scan state, under random gaps on both channels and several limit settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [7:0]  ChCr = 8'h0d;
  localparam logic [7:0]  ChLf = 8'h0a;
  localparam logic [7:0]  ChSp = 8'h20;
  localparam logic [7:0]  ChPlus = 8'h2b;
  localparam logic [7:0]  ChMinus = 8'h2d;
  localparam logic [7:0]  ChZero = 8'h30;
  localparam logic [7:0]  ChNine = 8'h39;

  typedef struct {
    int unsigned        progress;
    bit                 found;
    bit                 any;
    bit                 prev_cr;
    bit                 cr_first;
    hscan_pkg::phase_e  phase;
    bit                 neg;
    logic [31:0]        mag;
    bit                 lf_done;
    logic [31:0]        lf_val;
    bit                 crlf_done;
    logic [31:0]        crlf_val;
  } key_scan_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = hscan_pkg::CfgHeaderLimit;
  logic [hscan_pkg::CfgW-1:0] cfg_data_i = '0;

  hscan_if #(.payload_t(hscan_pkg::in_t))  in_ch ();
  hscan_if #(.payload_t(hscan_pkg::out_t)) out_ch ();

  http_header_end_and_length_scanner_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // scan state as the block should hold it
  int unsigned    hdr_lim = 65536;
  int unsigned    body_lim = 4194304;
  bit             in_body;
  hscan_pkg::em_e end_state;
  int unsigned    hdr_cnt;
  int unsigned    body_cnt;
  key_scan_t      key_scan [hscan_pkg::NKeys];
  logic [31:0]    len_found;

  string key_txt [hscan_pkg::NKeys] =
    '{"Content-Length:", "Content-length:", "content-length:"};

  hscan_pkg::out_t pending_results [$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned messages = 0;
  int unsigned kind_seen [6];
  int unsigned cycles = 0;
  int unsigned next_gap = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void clear_scan();
    in_body = 1'b0;
    end_state = hscan_pkg::EM_IDLE;
    hdr_cnt = 0;
    body_cnt = 0;
    len_found = 32'hffff_ffff;
    foreach (key_scan[i]) begin
      key_scan[i] = '{progress: 0, found: 0, any: 0, prev_cr: 0, cr_first: 0,
                      phase: hscan_pkg::PH_SKIP, neg: 0, mag: 32'd0, lf_done: 0,
                      lf_val: 32'd0, crlf_done: 0, crlf_val: 32'd0};
    end
  endfunction

  function automatic logic [31:0] value_so_far(key_scan_t k);
    if (k.phase == hscan_pkg::PH_SKIP || k.phase == hscan_pkg::PH_SIGN) return 32'd0;
    if (k.neg) return 32'd0 - k.mag;
    return (k.mag > 32'h7fff_ffff) ? 32'h7fff_ffff : k.mag;
  endfunction

  function automatic void value_char(int i, logic [7:0] b);
    key_scan_t k;
    bit first;
    bit digit;
    bit blank;
    longint unsigned m;
    k = key_scan[i];
    first = !k.any;
    digit = (b >= ChZero) && (b <= ChNine);
    blank = (b == ChSp) || (b >= 8'h09 && b <= 8'h0d);
    k.any = 1'b1;
    if (b == ChLf) begin
      if (!k.lf_done) begin
        k.lf_done = 1'b1;
        k.lf_val = first ? 32'hffff_ffff : value_so_far(key_scan[i]);
      end
      if (k.prev_cr && !k.crlf_done) begin
        k.crlf_done = 1'b1;
        k.crlf_val = k.cr_first ? 32'hffff_ffff : value_so_far(key_scan[i]);
      end
    end
    case (k.phase)
      hscan_pkg::PH_SKIP: begin
        if (!blank) begin
          if (b == ChPlus || b == ChMinus) begin
            k.neg = (b == ChMinus);
            k.phase = hscan_pkg::PH_SIGN;
          end else begin
            k.phase = digit ? hscan_pkg::PH_DIGITS : hscan_pkg::PH_DONE;
          end
        end
      end
      hscan_pkg::PH_SIGN: k.phase = digit ? hscan_pkg::PH_DIGITS : hscan_pkg::PH_DONE;
      hscan_pkg::PH_DIGITS: if (!digit) k.phase = hscan_pkg::PH_DONE;
      default: ;
    endcase
    if (k.phase == hscan_pkg::PH_DIGITS && digit) begin
      m = longint'(k.mag) * 10 + longint'(b - ChZero);
      k.mag = (m > 64'h8000_0000) ? 32'h8000_0000 : m[31:0];
    end
    k.prev_cr = (b == ChCr);
    k.cr_first = (b == ChCr) && first;
    key_scan[i] = k;
  endfunction

  function automatic void key_char_step(int i, logic [7:0] b);
    if (key_scan[i].found) begin
      value_char(i, b);
      return;
    end
    if (key_scan[i].progress < hscan_pkg::KeyLen &&
        b == key_txt[i][key_scan[i].progress])
      key_scan[i].progress++;
    else
      key_scan[i].progress = (b == key_txt[i][0]) ? 1 : 0;
    if (key_scan[i].progress >= hscan_pkg::KeyLen) key_scan[i].found = 1'b1;
  endfunction

  function automatic bit blank_line_step(logic [7:0] b);
    hscan_pkg::em_e s;
    s = end_state;
    if (b == ChLf) begin
      if (s == hscan_pkg::EM_LF || s == hscan_pkg::EM_CRLF || s == hscan_pkg::EM_CRLFCR) begin
        end_state = hscan_pkg::EM_IDLE;
        return 1'b1;
      end
      end_state = (s == hscan_pkg::EM_CR) ? hscan_pkg::EM_CRLF : hscan_pkg::EM_LF;
    end else if (b == ChCr) begin
      end_state = (s == hscan_pkg::EM_CRLF) ? hscan_pkg::EM_CRLFCR : hscan_pkg::EM_CR;
    end else begin
      end_state = hscan_pkg::EM_IDLE;
    end
    return 1'b0;
  endfunction

  function automatic hscan_pkg::out_t scan_byte(hscan_pkg::func_e fn, logic [7:0] b);
    hscan_pkg::out_t r;
    hscan_pkg::kind_e kind;
    int unsigned hl;
    int unsigned bl;
    if (fn == hscan_pkg::FUNC_RESTART) begin
      clear_scan();
      kind = hscan_pkg::KIND_RESTART;
    end else if (!in_body) begin
      hl = (hdr_lim < hscan_pkg::HeaderDepth) ? hdr_lim : hscan_pkg::HeaderDepth;
      if (hdr_cnt + 1 >= hl) begin
        kind = hscan_pkg::KIND_OVERFLOW;
      end else begin
        hdr_cnt++;
        for (int i = 0; i < hscan_pkg::NKeys; i++) key_char_step(i, b);
        kind = hscan_pkg::KIND_HEADER;
        if (blank_line_step(b)) begin
          in_body = 1'b1;
          kind = hscan_pkg::KIND_HDR_END;
          len_found = 32'hffff_ffff;
          // first key in priority order decides, even with no line end seen
          for (int i = 0; i < hscan_pkg::NKeys; i++) begin
            if (key_scan[i].found) begin
              if (key_scan[i].crlf_done) len_found = key_scan[i].crlf_val;
              else if (key_scan[i].lf_done) len_found = key_scan[i].lf_val;
              break;
            end
          end
        end
      end
    end else begin
      bl = (body_lim < hscan_pkg::BodyDepth) ? body_lim : hscan_pkg::BodyDepth;
      if ($signed(len_found) > 0 && body_cnt + 1 <= bl) begin
        body_cnt++;
        kind = hscan_pkg::KIND_BODY_OK;
      end else begin
        kind = hscan_pkg::KIND_BODY_REJ;
      end
    end
    r.byte_kind = kind;
    r.header_done = in_body;
    r.content_length = len_found;
    r.header_bytes = hdr_cnt[16:0];
    r.body_bytes = body_cnt[22:0];
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
  endfunction

  task automatic send_byte(hscan_pkg::func_e fn, logic [7:0] b);
    if (next_gap > 0) repeat (next_gap) @(posedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data <= '{func: fn, data_byte: b};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_results.push_back(scan_byte(fn, b));
    bytes_sent++;
    next_gap = draw_wait();
    if (next_gap > 0) in_ch.valid <= 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(hscan_pkg::FUNC_DATA, s[i]);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    next_gap = 0;
  endtask

  task automatic write_limit(logic [0:0] idx, int unsigned val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= hscan_pkg::CfgW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hscan_pkg::CfgHeaderLimit) hdr_lim = val & 32'h1ffff;
    else body_lim = val & 32'h7fffff;
  endtask

  function automatic string value_text();
    case ($urandom_range(0, 9))
      0: return "";
      1: return "   ";
      2: return ($urandom_range(0, 1) != 0) ? "+" : "-";
      3: return $sformatf("%0d%0d", $urandom, $urandom);
      4: return $sformatf("-%0d", $urandom_range(0, 99));
      5: return $sformatf("%0dx", $urandom_range(0, 15));
      6: return $sformatf("\t+%0d", $urandom_range(0, 15));
      default: return $sformatf(" %0d", $urandom_range(0, 15));
    endcase
  endfunction

  task automatic send_message();
    string line;
    int unsigned nlines;
    bit crlf;
    crlf = $urandom_range(0, 2) != 0;
    if ($urandom_range(0, 9) != 0) send_byte(hscan_pkg::FUNC_RESTART, 8'($urandom));
    messages++;
    nlines = $urandom_range(0, 3);
    for (int l = 0; l < nlines; l++) begin
      if ($urandom_range(0, 2) != 0) begin
        line = key_txt[$urandom_range(0, hscan_pkg::NKeys - 1)];
        if ($urandom_range(0, 5) == 0)
          line[$urandom_range(0, hscan_pkg::KeyLen - 1)] = 8'($urandom);
        line = {line, value_text()};
        send_text(line);
      end else begin
        for (int i = $urandom_range(0, 8); i > 0; i--)
          send_byte(hscan_pkg::FUNC_DATA, ($urandom_range(0, 7) == 0)
                                            ? 8'($urandom)
                                            : 8'($urandom_range(33, 126)));
      end
      if ($urandom_range(0, 9) != 0) send_text(crlf ? "\r\n" : "\n");
    end
    // terminator, sometimes broken by a stray byte
    if ($urandom_range(0, 11) == 0) send_byte(hscan_pkg::FUNC_DATA, 8'($urandom));
    send_text(crlf ? "\r\n\r\n" : "\n\n");
    for (int i = $urandom_range(0, 14); i > 0; i--)
      send_byte(hscan_pkg::FUNC_DATA, 8'($urandom));
  endtask

  task automatic test_directed();
    send_byte(hscan_pkg::FUNC_RESTART, 8'hff);
    send_text("content-length:-7\n\n");
    send_byte(hscan_pkg::FUNC_DATA, 8'h00);
    send_byte(hscan_pkg::FUNC_RESTART, 8'h00);
    send_byte(hscan_pkg::FUNC_DATA, 8'h00);
    send_byte(hscan_pkg::FUNC_DATA, 8'hff);
    send_text("\n\n");
    send_byte(hscan_pkg::FUNC_DATA, 8'h80);
  endtask

  task automatic test_limits();
    write_limit(hscan_pkg::CfgHeaderLimit, 2);
    send_byte(hscan_pkg::FUNC_RESTART, 8'h00);
    send_text("ab");
    write_limit(hscan_pkg::CfgHeaderLimit, 12);
    send_byte(hscan_pkg::FUNC_RESTART, 8'h00);
    send_text("Content-Length: 3\r\n\r\n");
    write_limit(hscan_pkg::CfgHeaderLimit, 65536);
    write_limit(hscan_pkg::CfgBodyLimit, 1);
    send_byte(hscan_pkg::FUNC_RESTART, 8'h00);
    send_text("Content-length: 5\r\n\r\nxyz");
    write_limit(hscan_pkg::CfgBodyLimit, 4194304);
  endtask

  task automatic test_random();
    int unsigned hl_set [4] = '{65536, 40, 200, 65536};
    int unsigned bl_set [4] = '{4194304, 8, 3, 1};
    for (int p = 0; p < 4; p++) begin
      write_limit(hscan_pkg::CfgHeaderLimit, hl_set[p]);
      write_limit(hscan_pkg::CfgBodyLimit, bl_set[p]);
      no_idle = (p == 2);
      while (bytes_sent < 1150 * (p + 1) / 4) begin
        send_message();
        if ($urandom_range(0, 39) == 0) drain_results();
      end
    end
    no_idle = 1'b0;
    write_limit(hscan_pkg::CfgBodyLimit, 4194304);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    hscan_pkg::out_t want;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = pending_results.pop_front();
          kind_seen[want.byte_kind]++;
          if (out_ch.data.byte_kind !== want.byte_kind) begin
            $error("byte_kind: expected %0d, got %0d", want.byte_kind, out_ch.data.byte_kind);
            errors++;
          end
          if (out_ch.data.header_done !== want.header_done) begin
            $error("header_done: expected %0d, got %0d", want.header_done,
                   out_ch.data.header_done);
            errors++;
          end
          if (out_ch.data.content_length !== want.content_length) begin
            $error("content_length: expected %0d, got %0d", $signed(want.content_length),
                   $signed(out_ch.data.content_length));
            errors++;
          end
          if (out_ch.data.header_bytes !== want.header_bytes) begin
            $error("header_bytes: expected %0d, got %0d", want.header_bytes,
                   out_ch.data.header_bytes);
            errors++;
          end
          if (out_ch.data.body_bytes !== want.body_bytes) begin
            $error("body_bytes: expected %0d, got %0d", want.body_bytes,
                   out_ch.data.body_bytes);
            errors++;
          end
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    clear_scan();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_random();
    drain_results();
    repeat (10) @(posedge clk_i);
    $display("%0d bytes in %0d messages, %0d results checked", bytes_sent, messages,
             results_seen);
    $display("kinds: header %0d, end %0d, body ok %0d, rejected %0d, overflow %0d, restart %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> http_header_end_and_length_scanner_unit.f
sv/hscan_pkg.sv
sv/hscan_if.sv
sv/http_header_end_and_length_scanner_unit.sv
sv/hscan_checker.sv
sim/testbench.sv
